>>> rtl/core/assert_macros.svh
// assertion macros used by the rtl controller cfda_ctrl
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> rtl/core/cfda_pkg.sv
// types and constants of the color feature distance accumulator
// no dependencies
`default_nettype none
package cfda_pkg;
    localparam int CH_W    = 8;
    localparam int SUM_W   = 40;
    localparam int ADD_W   = 20;
    localparam int DIST_W  = 48;
    localparam int PROD_W  = 80;
    localparam int ROOT_W  = 36;
    localparam int REM_W   = 40;
    localparam int CAND_W  = 114;
    localparam int QA_W    = 97;
    localparam int Q_W     = 17;
    localparam int CNT_W   = 6;
    localparam int BIT_W   = 5;

    localparam logic [1:0] METRIC_MANHATTAN  = 2'd0;
    localparam logic [1:0] METRIC_EUCLIDEAN  = 2'd1;
    localparam logic [1:0] METRIC_CHESSBOARD = 2'd2;
    localparam logic [1:0] METRIC_COSINE     = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0] first_ch0;
        logic [CH_W-1:0] first_ch1;
        logic [CH_W-1:0] first_ch2;
        logic [CH_W-1:0] second_ch0;
        logic [CH_W-1:0] second_ch1;
        logic [CH_W-1:0] second_ch2;
        logic            last;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              undefined_result;
    } t_out_item;

    typedef struct packed {
        logic             acc_en;
        logic             clear;
        logic             sqrt_init;
        logic             sqrt_step;
        logic             mul_init_a;
        logic             mul_init_d;
        logic             mul_step;
        logic             save_a;
        logic             save_d;
        logic             cos_init;
        logic             cos_add;
        logic             cos_cmp;
        logic             load_out;
        logic [BIT_W-1:0] bit_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic       out_valid;
        logic       zero_norm;
        logic [1:0] metric;
    } t_dp_status;
endpackage
`default_nettype wire

>>> rtl/core/cfda_datapath.sv
// datapath: accumulators, serial multiplier, square root and cosine quotient search
// depends on cfda_pkg
`default_nettype none
module cfda_datapath
    import cfda_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_data,
    input  wire t_in_item   i_in_data,
    input  wire logic       i_out_stall,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_status      o_status,
    output t_out_item       o_out_data
);
    localparam logic [CH_W-1:0] CH_MASK = CH_W'((17'd1 << CHANNEL_BITS) - 17'd1);
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    logic [1:0]        r_metric;
    logic [SUM_W-1:0]  r_main, r_n1, r_n2;
    logic [SUM_W-1:0]  r_sq_src;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  r_rem;
    logic [PROD_W-1:0] r_mul_acc, r_mul_a, r_prod_a, r_prod_d;
    logic [SUM_W-1:0]  r_mul_b;
    logic [CAND_W-1:0] r_p, r_cand;
    logic [QA_W-1:0]   r_qa;
    logic [Q_W-1:0]    r_q;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [CH_W-1:0]   a0, a1, a2, c0, c1, c2, d0, d1, d2, dmax;
    logic [ADD_W-1:0]  add, n1_add, n2_add;
    logic [SUM_W:0]    main_sum, n1_sum, n2_sum;
    logic [REM_W-1:0]  rem2, trial;
    logic [CAND_W-1:0] cand2;
    logic              take;
    t_out_item         n_out;

    assign a0 = i_in_data.first_ch0 & CH_MASK;
    assign a1 = i_in_data.first_ch1 & CH_MASK;
    assign a2 = i_in_data.first_ch2 & CH_MASK;
    assign c0 = i_in_data.second_ch0 & CH_MASK;
    assign c1 = i_in_data.second_ch1 & CH_MASK;
    assign c2 = i_in_data.second_ch2 & CH_MASK;
    assign d0 = (a0 > c0) ? a0 - c0 : c0 - a0;
    assign d1 = (a1 > c1) ? a1 - c1 : c1 - a1;
    assign d2 = (a2 > c2) ? a2 - c2 : c2 - a2;

    always_comb begin
        dmax = d0;
        if (d1 > dmax) dmax = d1;
        if (d2 > dmax) dmax = d2;
        case (r_metric)
            METRIC_MANHATTAN:  add = ADD_W'(d0) + ADD_W'(d1) + ADD_W'(d2);
            METRIC_EUCLIDEAN:  add = ADD_W'(d0 * d0) + ADD_W'(d1 * d1) + ADD_W'(d2 * d2);
            METRIC_CHESSBOARD: add = ADD_W'(dmax);
            default:           add = ADD_W'(a0 * c0) + ADD_W'(a1 * c1) + ADD_W'(a2 * c2);
        endcase
        n1_add = ADD_W'(a0 * a0) + ADD_W'(a1 * a1) + ADD_W'(a2 * a2);
        n2_add = ADD_W'(c0 * c0) + ADD_W'(c1 * c1) + ADD_W'(c2 * c2);
    end

    assign main_sum = {1'b0, r_main} + (SUM_W+1)'(add);
    assign n1_sum   = {1'b0, r_n1} + (SUM_W+1)'(n1_add);
    assign n2_sum   = {1'b0, r_n2} + (SUM_W+1)'(n2_add);

    // one root digit per step, source bits shift out from the top
    assign rem2  = {r_rem[REM_W-3:0], r_sq_src[SUM_W-1:SUM_W-2]};
    assign trial = REM_W'({r_root, 2'b01});

    // candidate q^2*A built incrementally: P + (q*A << b+1) + (A << 2b)
    assign cand2 = r_cand + (CAND_W'(r_prod_a) << {i_cmd.bit_idx, 1'b0});
    assign take  = !r_q[Q_W-1] && (cand2 <= CAND_W'({r_prod_d, 32'd0}));

    always_comb begin
        n_out.undefined_result = 1'b0;
        case (r_metric)
            METRIC_EUCLIDEAN: n_out.distance = DIST_W'(r_root);
            METRIC_COSINE: begin
                if (o_status.zero_norm) begin
                    n_out.distance         = '0;
                    n_out.undefined_result = 1'b1;
                end else begin
                    n_out.distance = DIST_W'(18'd65536 - 18'(r_q));
                end
            end
            default: begin
                if (r_main[SUM_W-1:32] != '0) n_out.distance = '1;
                else                          n_out.distance = {r_main[31:0], 16'd0};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric    <= METRIC_MANHATTAN;
            r_main      <= '0;
            r_n1        <= '0;
            r_n2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_metric <= i_cfg_data;
            if (i_cmd.clear) begin
                r_main <= '0;
                r_n1   <= '0;
                r_n2   <= '0;
            end else if (i_cmd.acc_en) begin
                r_main <= main_sum[SUM_W] ? SUM_MAX : main_sum[SUM_W-1:0];
                r_n1   <= n1_sum[SUM_W] ? SUM_MAX : n1_sum[SUM_W-1:0];
                r_n2   <= n2_sum[SUM_W] ? SUM_MAX : n2_sum[SUM_W-1:0];
            end
            if (i_cmd.load_out)   r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) r_out <= n_out;
        if (i_cmd.sqrt_init) begin
            r_sq_src <= r_main;
            r_root   <= '0;
            r_rem    <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sq_src <= {r_sq_src[SUM_W-3:0], 2'b00};
            if (rem2 >= trial) begin
                r_rem  <= rem2 - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem2;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.mul_init_a) begin
            r_mul_acc <= '0;
            r_mul_a   <= PROD_W'(r_n1);
            r_mul_b   <= r_n2;
        end else if (i_cmd.mul_init_d) begin
            r_mul_acc <= '0;
            r_mul_a   <= PROD_W'(r_main);
            r_mul_b   <= r_main;
        end else if (i_cmd.mul_step) begin
            if (r_mul_b[0]) r_mul_acc <= r_mul_acc + r_mul_a;
            r_mul_a <= {r_mul_a[PROD_W-2:0], 1'b0};
            r_mul_b <= {1'b0, r_mul_b[SUM_W-1:1]};
        end
        if (i_cmd.save_a) r_prod_a <= r_mul_acc;
        if (i_cmd.save_d) r_prod_d <= r_mul_acc;
        if (i_cmd.cos_init) begin
            r_p  <= '0;
            r_qa <= '0;
            r_q  <= '0;
        end else if (i_cmd.cos_add) begin
            r_cand <= r_p + (CAND_W'(r_qa) << ({1'b0, i_cmd.bit_idx} + 6'd1));
        end else if (i_cmd.cos_cmp && take) begin
            r_p  <= cand2;
            r_qa <= r_qa + (QA_W'(r_prod_a) << i_cmd.bit_idx);
            r_q  <= r_q | (Q_W'(1) << i_cmd.bit_idx);
        end
    end

    assign o_status.out_valid = r_out_valid;
    assign o_status.zero_norm = (r_n1 == '0) || (r_n2 == '0);
    assign o_status.metric    = r_metric;
    assign o_out_data         = r_out;
endmodule
`default_nettype wire

>>> rtl/core/cfda_ctrl.sv
// controller: sequences accumulation and the per-vector finishing steps
// depends on cfda_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module cfda_ctrl
    import cfda_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_last,
    input  wire logic       i_out_stall,
    input  wire t_dp_status i_status,
    output logic            o_in_stall,
    output t_dp_cmd         o_cmd
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PREP  = 10'b0000000010,
        S_SQRT  = 10'b0000000100,
        S_MULA  = 10'b0000001000,
        S_SAVEA = 10'b0000010000,
        S_MULD  = 10'b0000100000,
        S_COSI  = 10'b0001000000,
        S_CADD  = 10'b0010000000,
        S_CCMP  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             out_free, accept;

    assign out_free   = !i_status.out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || (i_status.out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_cmd         = '0;
        o_cmd.bit_idx = r_cnt[BIT_W-1:0];
        case (r_state)
            S_IDLE: begin
                o_cmd.acc_en = accept;
                if (accept && i_in_last) n_state = S_PREP;
            end
            S_PREP: begin
                if (i_status.metric == METRIC_EUCLIDEAN) begin
                    o_cmd.sqrt_init = 1'b1;
                    n_cnt           = CNT_W'(ROOT_W - 1);
                    n_state         = S_SQRT;
                end else if (i_status.metric == METRIC_COSINE && !i_status.zero_norm) begin
                    o_cmd.mul_init_a = 1'b1;
                    n_cnt            = CNT_W'(SUM_W - 1);
                    n_state          = S_MULA;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt           = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_DONE;
            end
            S_MULA: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_SAVEA;
            end
            S_SAVEA: begin
                o_cmd.save_a     = 1'b1;
                o_cmd.mul_init_d = 1'b1;
                n_cnt            = CNT_W'(SUM_W - 1);
                n_state          = S_MULD;
            end
            S_MULD: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_COSI;
            end
            S_COSI: begin
                o_cmd.save_d   = 1'b1;
                o_cmd.cos_init = 1'b1;
                n_cnt          = CNT_W'(Q_W - 1);
                n_state        = S_CADD;
            end
            S_CADD: begin
                o_cmd.cos_add = 1'b1;
                n_state       = S_CCMP;
            end
            S_CCMP: begin
                o_cmd.cos_cmp = 1'b1;
                n_cnt         = r_cnt - 1'b1;
                n_state       = (r_cnt == '0) ? S_DONE : S_CADD;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // quotient compare always follows its partial-sum cycle
    `ASSERT_AT(a_cmp_after_add, i_clk, i_rst_n, o_cmd.cos_cmp |-> $past(o_cmd.cos_add))
    `ASSERT_NEVER(a_acc_with_load, i_clk, i_rst_n, o_cmd.acc_en && o_cmd.load_out)
    `ASSERT_AT(a_load_needs_room, i_clk, i_rst_n, o_cmd.load_out |-> out_free)
    `ASSERT_AT(a_sqrt_ends, i_clk, i_rst_n,
        (r_state == S_SQRT && r_cnt == '0) |=> (r_state == S_DONE))
endmodule
`default_nettype wire

>>> rtl/core/color_feature_distance_accumulator.sv
// one input request per cycle while elements are not last and no stalled result waits; a last
// element's result request follows prepare (manhattan, chessboard, cosine with a zero norm),
// root steps (euclidean, one root digit per cycle) or two 40-step products and 17 quotient
// bits (cosine); input reopens the cycle after the result loads; a stalled result request
// holds it off; synchronous active-low reset clears the sums, the metric and the result valid
// top level; depends on cfda_pkg, cfda_ctrl, cfda_datapath
`default_nettype none
module color_feature_distance_accumulator
    import cfda_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_item   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_item       o_out_data
);
    t_dp_cmd    cmd;
    t_dp_status status;

    cfda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.last),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    cfda_datapath #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (o_out_data)
    );

    assign o_out_valid = status.out_valid;
endmodule
`default_nettype wire
